// ===== hdl/note_voice_tracking_table_defines.svh =====
// assertion helpers for the note voice tracking table
`ifndef NOTE_VOICE_TRACKING_TABLE_DEFINES_SVH
`define NOTE_VOICE_TRACKING_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NVTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define NVTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/nvtt_pkg.sv =====
package nvtt_pkg;

    localparam int NOTE_COUNT    = 128;
    localparam int MAX_LAYERS    = 32;
    localparam int VOICE_ID_BITS = 8;
    localparam int NOTE_BITS     = $clog2(NOTE_COUNT);
    localparam int LAYER_BITS    = $clog2(MAX_LAYERS);
    localparam int CNT_BITS      = $clog2(MAX_LAYERS + 1);
    localparam int ADDR_BITS     = NOTE_BITS + LAYER_BITS;
    localparam int VOICE_DEPTH   = NOTE_COUNT * MAX_LAYERS;

    // port field widths
    localparam int NOTE_W   = 8;
    localparam int ID_W     = 8;
    localparam int STATUS_W = 3;
    localparam int LIMIT_W  = 7;
    localparam int LIMIT_RESET = 32;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED    = 3'd0,
        ST_BAD_NOTE  = 3'd1,
        ST_NO_VOICE  = 3'd2,
        ST_LIST_FULL = 3'd3,
        ST_RELEASE   = 3'd4,
        ST_NOTHING   = 3'd5
    } t_status;

    typedef enum logic {
        OP_TRIGGER = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_WALK
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    cap_item;
        logic    store;
        logic    walk_start;
        logic    walk_next;
        logic    clear_cnt;
        logic    out_load;
        t_status out_status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic bad_note;
        logic is_release;
        logic voice_valid;
        logic full;
        logic empty;
        logic walk_last;
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/nvtt_if.sv =====
interface nvtt_in_if;
    logic                       valid;
    logic                       ready;
    logic [0:0]                 op;
    logic [nvtt_pkg::NOTE_W-1:0] note;
    logic [0:0]                 voice_valid;
    logic [nvtt_pkg::ID_W-1:0]   voice_id;

    modport source (output valid, op, note, voice_valid, voice_id, input ready);
    modport sink   (input valid, op, note, voice_valid, voice_id, output ready);
endinterface

interface nvtt_out_if;
    logic                          valid;
    logic                          ready;
    logic [nvtt_pkg::STATUS_W-1:0] status;
    logic [nvtt_pkg::ID_W-1:0]     release_voice;
    logic [0:0]                    last;

    modport source (output valid, status, release_voice, last, input ready);
    modport sink   (input valid, status, release_voice, last, output ready);
endinterface

interface nvtt_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [nvtt_pkg::LIMIT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/nvtt_datapath.sv =====
module nvtt_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nvtt_pkg::t_cmd                i_cmd,
    output nvtt_pkg::t_stat               o_stat,
    input  logic [0:0]                    i_op,
    input  logic [nvtt_pkg::NOTE_W-1:0]   i_note,
    input  logic [0:0]                    i_voice_valid,
    input  logic [nvtt_pkg::ID_W-1:0]     i_voice_id,
    nvtt_cfg_if.sink                      i_cfg,
    nvtt_out_if.source                    o_out
);

    // captured item
    logic                                r_op;
    logic                                r_bad;
    logic                                r_vv;
    logic [nvtt_pkg::NOTE_BITS-1:0]      r_note;
    logic [nvtt_pkg::VOICE_ID_BITS-1:0]  r_vid;

    // per-note counts, valid bits stand for the reset value
    logic [nvtt_pkg::CNT_BITS-1:0]       r_cnt_mem [nvtt_pkg::NOTE_COUNT];
    logic [nvtt_pkg::NOTE_COUNT-1:0]     r_cnt_vld;
    logic [nvtt_pkg::CNT_BITS-1:0]       r_cnt_q;
    logic                                r_cnt_hit;
    logic [nvtt_pkg::CNT_BITS-1:0]       w_cnt;
    logic                                w_cnt_we;
    logic [nvtt_pkg::CNT_BITS-1:0]       w_cnt_wd;

    // stored voice ids
    logic [nvtt_pkg::VOICE_ID_BITS-1:0]  r_voice_mem [nvtt_pkg::VOICE_DEPTH];
    logic [nvtt_pkg::VOICE_ID_BITS-1:0]  r_voice_q;
    logic [nvtt_pkg::LAYER_BITS-1:0]     r_idx;
    logic [nvtt_pkg::LAYER_BITS-1:0]     n_idx;

    logic [nvtt_pkg::LIMIT_W-1:0]        r_limit;
    logic [nvtt_pkg::CNT_BITS-1:0]       w_cap;

    logic                                r_out_valid;
    nvtt_pkg::t_status                   r_out_status;
    logic [nvtt_pkg::ID_W-1:0]           r_out_voice;
    logic                                r_out_last;
    logic                                w_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_item) begin
            r_op   <= i_op[0];
            r_bad  <= (i_note >= nvtt_pkg::NOTE_W'(nvtt_pkg::NOTE_COUNT));
            r_vv   <= i_voice_valid[0];
            r_note <= i_note[nvtt_pkg::NOTE_BITS-1:0];
            r_vid  <= i_voice_id[nvtt_pkg::VOICE_ID_BITS-1:0];
        end
    end

    // count memory
    assign w_cnt    = r_cnt_hit ? r_cnt_q : '0;
    assign w_cnt_we = i_cmd.store | i_cmd.clear_cnt;
    assign w_cnt_wd = i_cmd.store ? (w_cnt + nvtt_pkg::CNT_BITS'(1)) : '0;

    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            r_cnt_mem[r_note] <= w_cnt_wd;
        end
        if (i_cmd.cap_item) begin
            r_cnt_q <= r_cnt_mem[i_note[nvtt_pkg::NOTE_BITS-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
            r_cnt_hit <= 1'b0;
        end else begin
            if (w_cnt_we) begin
                r_cnt_vld[r_note] <= 1'b1;
            end
            if (i_cmd.cap_item) begin
                r_cnt_hit <= r_cnt_vld[i_note[nvtt_pkg::NOTE_BITS-1:0]];
            end
        end
    end

    // voice memory
    assign n_idx = i_cmd.walk_start ? '0 : (r_idx + nvtt_pkg::LAYER_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_voice_mem[{r_note, w_cnt[nvtt_pkg::LAYER_BITS-1:0]}] <= r_vid;
        end
        if (i_cmd.walk_start || i_cmd.walk_next) begin
            r_voice_q <= r_voice_mem[{r_note, n_idx}];
            r_idx     <= n_idx;
        end
    end

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= nvtt_pkg::LIMIT_W'(nvtt_pkg::LIMIT_RESET);
        end else if (i_cfg.valid) begin
            r_limit <= i_cfg.data;
        end
    end

    assign w_cap = (r_limit > nvtt_pkg::LIMIT_W'(nvtt_pkg::MAX_LAYERS))
                 ? nvtt_pkg::CNT_BITS'(nvtt_pkg::MAX_LAYERS)
                 : r_limit[nvtt_pkg::CNT_BITS-1:0];

    assign w_last = ((nvtt_pkg::CNT_BITS'(r_idx) + nvtt_pkg::CNT_BITS'(1)) == w_cnt);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            if (i_cmd.out_status == nvtt_pkg::ST_RELEASE) begin
                r_out_voice <= nvtt_pkg::ID_W'(r_voice_q);
                r_out_last  <= w_last;
            end else begin
                r_out_voice <= '0;
                r_out_last  <= 1'b1;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.release_voice = r_out_voice;
    assign o_out.last          = r_out_last;

    assign o_stat.bad_note    = r_bad;
    assign o_stat.is_release  = (r_op == nvtt_pkg::OP_RELEASE);
    assign o_stat.voice_valid = r_vv;
    assign o_stat.full        = (w_cnt >= w_cap);
    assign o_stat.empty       = (w_cnt == '0);
    assign o_stat.walk_last   = w_last;
    assign o_stat.out_free    = !r_out_valid || o_out.ready;

endmodule

// ===== hdl/nvtt_ctrl.sv =====
module nvtt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  nvtt_pkg::t_stat i_stat,
    output nvtt_pkg::t_cmd  o_cmd
);

    nvtt_pkg::t_state r_state;
    nvtt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nvtt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nvtt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = nvtt_pkg::S_LOOKUP;
                end
            end
            nvtt_pkg::S_LOOKUP: begin
                if (i_stat.out_free) begin
                    if (!i_stat.bad_note && i_stat.is_release && !i_stat.empty) begin
                        n_state = nvtt_pkg::S_WALK;
                    end else begin
                        n_state = nvtt_pkg::S_IDLE;
                    end
                end
            end
            nvtt_pkg::S_WALK: begin
                if (i_stat.out_free && i_stat.walk_last) begin
                    n_state = nvtt_pkg::S_IDLE;
                end
            end
            default: n_state = nvtt_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.out_status = nvtt_pkg::ST_STORED;
        unique case (r_state)
            nvtt_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.cap_item = i_in_valid;
            end
            nvtt_pkg::S_LOOKUP: begin
                if (i_stat.out_free) begin
                    priority if (i_stat.bad_note) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = nvtt_pkg::ST_BAD_NOTE;
                    end else if (!i_stat.is_release && !i_stat.voice_valid) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = nvtt_pkg::ST_NO_VOICE;
                    end else if (!i_stat.is_release && i_stat.full) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = nvtt_pkg::ST_LIST_FULL;
                    end else if (!i_stat.is_release) begin
                        o_cmd.store      = 1'b1;
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = nvtt_pkg::ST_STORED;
                    end else if (i_stat.empty) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = nvtt_pkg::ST_NOTHING;
                    end else begin
                        o_cmd.walk_start = 1'b1;
                    end
                end
            end
            nvtt_pkg::S_WALK: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = nvtt_pkg::ST_RELEASE;
                    if (i_stat.walk_last) begin
                        o_cmd.clear_cnt = 1'b1;
                    end else begin
                        o_cmd.walk_next = 1'b1;
                    end
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/note_voice_tracking_table.sv =====
// note voice tracking table
// keeps, per midi note, the voice ids sounding it (up to the polyphony limit)
// channels: i_in (op, note, voice_valid, voice_id), o_out (status,
// release_voice, last), i_cfg (polyphony_limit write, always ready)
// each item is taken in the idle state, then the per-note count is looked up
// in a registered count memory; a trigger result is loaded into the output
// register as the lookup ends, and the input is ready again only after that
// a release of n held ids walks the voice memory: the first id is read in the
// lookup state, then the walk loads one result per cycle while the output
// drains; a release with nothing held or a bad note answers like a trigger
// the next item is taken while the last result still waits in the output register
// if the receiver stalls, the walk and the lookup hold and resume when it drains
// reset clears the per-note counts at once through a valid bit per note,
// sets polyphony_limit to 32, and empties the output register; the voice
// memory holds no reset and needs no clearing pass
// config writes are meant to happen only while the block is idle
`include "note_voice_tracking_table_defines.svh"

module note_voice_tracking_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nvtt_in_if.sink     i_in,
    nvtt_cfg_if.sink    i_cfg,
    nvtt_out_if.source  o_out
);

    nvtt_pkg::t_cmd  w_cmd;
    nvtt_pkg::t_stat w_stat;
    logic            w_in_ready;

    // sequencer: idle, count lookup, release walk
    nvtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    assign i_in.ready = w_in_ready;

    // count memory, voice memory, config and output register
    nvtt_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_op          (i_in.op),
        .i_note        (i_in.note),
        .i_voice_valid (i_in.voice_valid),
        .i_voice_id    (i_in.voice_id),
        .i_cfg         (i_cfg),
        .o_out         (o_out)
    );

    // an accepted item blocks the input for at least the lookup cycle
    `NVTT_ASSERT_NEXT(a_accept_blocks, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "input ready right after accept")
    // only a release walk produces a non-final item
    `NVTT_ASSERT_NOW(a_nonlast_release, i_clk, i_rst_n, o_out.valid && !o_out.last, o_out.status == nvtt_pkg::ST_RELEASE, "non-final item that is not a release")
    // a voice id shows only on release items
    `NVTT_ASSERT_NOW(a_voice_on_release, i_clk, i_rst_n, o_out.valid && (o_out.release_voice != '0), o_out.status == nvtt_pkg::ST_RELEASE, "voice id on a non-release item")
    // the datapath never gets conflicting memory commands
    `NVTT_ASSERT_NOW(a_cmd_exclusive, i_clk, i_rst_n, 1'b1, $onehot0({w_cmd.cap_item, w_cmd.store, w_cmd.walk_start, w_cmd.walk_next, w_cmd.clear_cnt}), "conflicting datapath commands")

endmodule

// ===== test/tb_note_voice_tracking_table.sv =====
`timescale 1ns / 100ps

module tb_note_voice_tracking_table;

    // run limits
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int ROW_COUNT     = 25;
    localparam int PHASE_ITEMS   = 40;
    localparam int REPORT_LIMIT  = 10;

    // one note event as driven on the input channel
    typedef struct packed {
        nvtt_pkg::t_op               op;
        logic [nvtt_pkg::NOTE_W-1:0] note;
        logic                        voice_valid;
        logic [nvtt_pkg::ID_W-1:0]   voice_id;
    } t_note_event;

    // one answer as seen on the output channel
    typedef struct packed {
        nvtt_pkg::t_status         status;
        logic [nvtt_pkg::ID_W-1:0] voice;
        logic                      last;
    } t_voice_answer;

    typedef enum logic {
        ROW_ITEM,
        ROW_LIMIT
    } t_row_kind;

    // directed stimulus row: either an item or a polyphony limit write
    typedef struct packed {
        t_row_kind                    kind;
        t_note_event                  ev;
        logic [nvtt_pkg::LIMIT_W-1:0] limit;
        logic                         fixed;
        t_voice_answer                answer;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    nvtt_in_if  in_if ();
    nvtt_cfg_if cfg_if ();
    nvtt_out_if out_if ();

    note_voice_tracking_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // shadow copy of the table and the limit register
    logic [nvtt_pkg::LIMIT_W-1:0] layer_limit;
    logic [6:0]                   voice_count [nvtt_pkg::NOTE_COUNT];
    logic [nvtt_pkg::ID_W-1:0]    voice_list  [nvtt_pkg::NOTE_COUNT][nvtt_pkg::MAX_LAYERS];

    // answers of the latest event, then all answers still owed by the block
    t_voice_answer step_answers[$];
    t_voice_answer expected_answers[$];

    int  mismatch_count;
    int  accepted_items;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_armed;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // appends one answer to those of the latest event
    function automatic void add_step_answer(input nvtt_pkg::t_status status,
                                            input logic [nvtt_pkg::ID_W-1:0] voice,
                                            input logic last);
        t_voice_answer a;
        a.status = status;
        a.voice  = voice;
        a.last   = last;
        step_answers = {step_answers, a};
    endfunction

    // works out the answers of one accepted event and updates the shadow table
    function automatic void track_note_event(input t_note_event ev);
        int slot;
        int used;
        int room;
        step_answers.delete();
        slot = ev.note[nvtt_pkg::NOTE_BITS-1:0];
        if (ev.note >= nvtt_pkg::NOTE_COUNT) begin
            // out of range note, table untouched
            add_step_answer(nvtt_pkg::ST_BAD_NOTE, '0, 1'b1);
        end else begin
            used = voice_count[slot];
            if (used > nvtt_pkg::MAX_LAYERS) used = nvtt_pkg::MAX_LAYERS;
            // capacity saturates at the number of layers
            room = (layer_limit > nvtt_pkg::MAX_LAYERS) ? nvtt_pkg::MAX_LAYERS
                                                        : int'(layer_limit);
            if (ev.op == nvtt_pkg::OP_TRIGGER) begin
                if (!ev.voice_valid) begin
                    add_step_answer(nvtt_pkg::ST_NO_VOICE, '0, 1'b1);
                end else if (used >= room) begin
                    // also covers a zero limit and a lowered limit
                    add_step_answer(nvtt_pkg::ST_LIST_FULL, '0, 1'b1);
                end else begin
                    voice_list[slot][used] = ev.voice_id;
                    voice_count[slot] = 7'(used + 1);
                    add_step_answer(nvtt_pkg::ST_STORED, '0, 1'b1);
                end
            end else if (used == 0) begin
                add_step_answer(nvtt_pkg::ST_NOTHING, '0, 1'b1);
            end else begin
                // held ids come out in the order they were stored
                for (int k = 0; k < used; k++) begin
                    add_step_answer(nvtt_pkg::ST_RELEASE, voice_list[slot][k],
                                    (k == used - 1));
                end
                voice_count[slot] = '0;
            end
        end
    endfunction

    // offers one item, with random gaps, and books its answers when taken
    task automatic send_event(input t_note_event ev, input bit fixed,
                              input t_voice_answer fixed_answer);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid       = 1'b1;
        in_if.op          = ev.op;
        in_if.note        = ev.note;
        in_if.voice_valid = ev.voice_valid;
        in_if.voice_id    = ev.voice_id;
        forever begin
            @(posedge i_clk);
            if (in_if.ready) break;
        end
        track_note_event(ev);
        // rows with a typed answer use it, the shadow table still advances
        if (fixed) expected_answers = {expected_answers, fixed_answer};
        else foreach (step_answers[k]) expected_answers = {expected_answers, step_answers[k]};
        if (ev.note < nvtt_pkg::NOTE_COUNT) accepted_items++;
    endtask

    // drops valid and waits until every owed answer has come out
    task automatic wait_for_idle();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (expected_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // polyphony limit write, only with the block idle
    task automatic write_layer_limit(input logic [nvtt_pkg::LIMIT_W-1:0] value);
        wait_for_idle();
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.data  = value;
        forever begin
            @(posedge i_clk);
            if (cfg_if.ready) break;
        end
        layer_limit = value;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic report_mismatch(input t_voice_answer want, input t_voice_answer got,
                                   input bit orphan);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            if (orphan)
                $display("check: result with none expected: status=%0d voice=%0d last=%0d",
                         got.status, got.voice, got.last);
            else
                $display("check: expected status=%0d voice=%0d last=%0d, got %0d %0d %0d",
                         want.status, want.voice, want.last,
                         got.status, got.voice, got.last);
        end
    endtask

    // result checker, sampled at the rising edge
    always @(posedge i_clk) begin : answer_check
        t_voice_answer want;
        t_voice_answer got;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got = '{nvtt_pkg::t_status'(out_if.status), out_if.release_voice, out_if.last};
            if (expected_answers.size() == 0) begin
                report_mismatch('0, got, 1'b1);
            end else begin
                want = expected_answers.pop_front();
                if (got !== want) report_mismatch(want, got, 1'b0);
            end
        end
    end

    // receiver: random back pressure, plus one long hold-off when armed
    initial begin : answer_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_if.ready = 1'b0;
                hold_left--;
            end else if (hold_armed && !hold_done) begin
                // block fills up and must stall its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_if.ready = 1'b0;
            end else begin
                out_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // main stimulus
    initial begin : stimulus
        t_stim_row                    rows [ROW_COUNT];
        t_note_event                  ev;
        logic [6:0]                   hot_notes [8];
        logic [nvtt_pkg::LIMIT_W-1:0] limit_plan [6];
        int                           burst;
        int                           target;

        // every input known from time zero
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.op          = '0;
        in_if.note        = '0;
        in_if.voice_valid = '0;
        in_if.voice_id    = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.data       = '0;
        hold_armed        = 1'b0;
        mismatch_count    = 0;
        accepted_items    = 0;
        send_idle_pct     = 14;
        recv_idle_pct     = 53;

        // shadow state after reset
        layer_limit = nvtt_pkg::LIMIT_W'(nvtt_pkg::LIMIT_RESET);
        foreach (voice_count[n]) voice_count[n] = '0;
        foreach (voice_list[n, k]) voice_list[n][k] = '0;

        // directed table: kind, event, limit, fixed flag, typed answer
        rows[0]  = '{ROW_ITEM,  '{nvtt_pkg::OP_RELEASE, 8'd0,   1'b0, 8'h00}, 7'd0, 1'b1,
                     '{nvtt_pkg::ST_NOTHING,   8'h00, 1'b1}};
        rows[1]  = '{ROW_ITEM,  '{nvtt_pkg::OP_TRIGGER, 8'd255, 1'b1, 8'hFF}, 7'd0, 1'b1,
                     '{nvtt_pkg::ST_BAD_NOTE,  8'h00, 1'b1}};
        rows[2]  = '{ROW_ITEM,  '{nvtt_pkg::OP_RELEASE, 8'd128, 1'b1, 8'h00}, 7'd0, 1'b1,
                     '{nvtt_pkg::ST_BAD_NOTE,  8'h00, 1'b1}};
        rows[3]  = '{ROW_ITEM,  '{nvtt_pkg::OP_TRIGGER, 8'd0,   1'b0, 8'hAA}, 7'd0, 1'b1,
                     '{nvtt_pkg::ST_NO_VOICE,  8'h00, 1'b1}};
        rows[4]  = '{ROW_ITEM,  '{nvtt_pkg::OP_TRIGGER, 8'd0,   1'b1, 8'h00}, 7'd0, 1'b1,
                     '{nvtt_pkg::ST_STORED,    8'h00, 1'b1}};
        rows[5]  = '{ROW_ITEM,  '{nvtt_pkg::OP_TRIGGER, 8'd0,   1'b1, 8'hFF}, 7'd0, 1'b1,
                     '{nvtt_pkg::ST_STORED,    8'h00, 1'b1}};
        rows[6]  = '{ROW_ITEM,  '{nvtt_pkg::OP_TRIGGER, 8'd127, 1'b1, 8'h55}, 7'd0, 1'b1,
                     '{nvtt_pkg::ST_STORED,    8'h00, 1'b1}};
        rows[7]  = '{ROW_ITEM,  '{nvtt_pkg::OP_RELEASE, 8'd0,   1'b0, 8'h00}, 7'd0, 1'b0, '0};
        rows[8]  = '{ROW_ITEM,  '{nvtt_pkg::OP_RELEASE, 8'd127, 1'b0, 8'h00}, 7'd0, 1'b0, '0};
        // zero limit: every granted trigger is refused
        rows[9]  = '{ROW_LIMIT, '0, 7'd0, 1'b0, '0};
        rows[10] = '{ROW_ITEM,  '{nvtt_pkg::OP_TRIGGER, 8'd5,   1'b1, 8'h12}, 7'd0, 1'b1,
                     '{nvtt_pkg::ST_LIST_FULL, 8'h00, 1'b1}};
        rows[11] = '{ROW_ITEM,  '{nvtt_pkg::OP_RELEASE, 8'd5,   1'b0, 8'h00}, 7'd0, 1'b1,
                     '{nvtt_pkg::ST_NOTHING,   8'h00, 1'b1}};
        // fill a list to its limit
        rows[12] = '{ROW_LIMIT, '0, 7'd2, 1'b0, '0};
        rows[13] = '{ROW_ITEM,  '{nvtt_pkg::OP_TRIGGER, 8'd9,   1'b1, 8'h01}, 7'd0, 1'b0, '0};
        rows[14] = '{ROW_ITEM,  '{nvtt_pkg::OP_TRIGGER, 8'd9,   1'b1, 8'h02}, 7'd0, 1'b0, '0};
        rows[15] = '{ROW_ITEM,  '{nvtt_pkg::OP_TRIGGER, 8'd9,   1'b1, 8'h03}, 7'd0, 1'b1,
                     '{nvtt_pkg::ST_LIST_FULL, 8'h00, 1'b1}};
        // lowered limit: held ids survive and all come out on release
        rows[16] = '{ROW_LIMIT, '0, 7'd1, 1'b0, '0};
        rows[17] = '{ROW_ITEM,  '{nvtt_pkg::OP_TRIGGER, 8'd9,   1'b1, 8'h04}, 7'd0, 1'b0, '0};
        rows[18] = '{ROW_ITEM,  '{nvtt_pkg::OP_RELEASE, 8'd9,   1'b0, 8'h00}, 7'd0, 1'b0, '0};
        rows[19] = '{ROW_ITEM,  '{nvtt_pkg::OP_TRIGGER, 8'd9,   1'b1, 8'h05}, 7'd0, 1'b0, '0};
        rows[20] = '{ROW_ITEM,  '{nvtt_pkg::OP_TRIGGER, 8'd9,   1'b1, 8'h06}, 7'd0, 1'b0, '0};
        rows[21] = '{ROW_ITEM,  '{nvtt_pkg::OP_RELEASE, 8'd9,   1'b0, 8'h00}, 7'd0, 1'b0, '0};
        // limit far above the layer count
        rows[22] = '{ROW_LIMIT, '0, 7'd127, 1'b0, '0};
        rows[23] = '{ROW_ITEM,  '{nvtt_pkg::OP_TRIGGER, 8'd64,  1'b1, 8'h80}, 7'd0, 1'b0, '0};
        rows[24] = '{ROW_ITEM,  '{nvtt_pkg::OP_RELEASE, 8'd64,  1'b1, 8'h7F}, 7'd0, 1'b0, '0};

        // synchronous reset, released at a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part
        foreach (rows[r]) begin
            if (rows[r].kind == ROW_LIMIT) write_layer_limit(rows[r].limit);
            else send_event(rows[r].ev, rows[r].fixed, rows[r].answer);
        end

        // random part: a few notes take most of the traffic so lists fill up
        foreach (hot_notes[h]) hot_notes[h] = 7'($urandom_range(0, nvtt_pkg::NOTE_COUNT - 1));
        limit_plan = '{7'd64, 7'd3, 7'd127, 7'd1, 7'($urandom_range(0, 127)), 7'd32};

        for (int ph = 0; ph < 3; ph++) begin
            // receiver idles more, then sender idles more, then no idling
            case (ph)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct = 53;
                end
                1: begin
                    send_idle_pct = 53;
                    recv_idle_pct = 14;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int sub = 0; sub < 2; sub++) begin
                write_layer_limit(limit_plan[ph * 2 + sub]);
                // long receiver hold-off while items keep coming
                if (ph == 2 && sub == 0) hold_armed = 1'b1;
                target = accepted_items + PHASE_ITEMS;
                while (accepted_items < target) begin
                    if ($urandom_range(0, 3) == 0) begin
                        // noise: any op, sometimes an out of range note
                        ev.op          = nvtt_pkg::t_op'($urandom_range(0, 1));
                        ev.note        = ($urandom_range(0, 3) == 0) ?
                                         8'($urandom_range(nvtt_pkg::NOTE_COUNT, 255)) :
                                         8'($urandom_range(0, nvtt_pkg::NOTE_COUNT - 1));
                        ev.voice_valid = 1'($urandom_range(0, 1));
                        ev.voice_id    = 8'($urandom_range(0, 255));
                        send_event(ev, 1'b0, '0);
                    end else begin
                        // burst of triggers on one note, mostly followed by its release
                        ev.note = {1'b0, hot_notes[$urandom_range(0, 7)]};
                        burst   = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 36) :
                                                                $urandom_range(1, 6);
                        ev.op   = nvtt_pkg::OP_TRIGGER;
                        for (int k = 0; k < burst; k++) begin
                            ev.voice_valid = ($urandom_range(0, 9) != 0);
                            ev.voice_id    = 8'($urandom_range(0, 255));
                            send_event(ev, 1'b0, '0);
                        end
                        if ($urandom_range(0, 6) != 0) begin
                            ev.op          = nvtt_pkg::OP_RELEASE;
                            ev.voice_valid = 1'($urandom_range(0, 1));
                            ev.voice_id    = 8'($urandom_range(0, 255));
                            send_event(ev, 1'b0, '0);
                        end
                    end
                end
            end
        end

        // drain and settle, then the verdict
        wait_for_idle();
        if (mismatch_count == 0 && expected_answers.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/nvtt_pkg.sv
hdl/nvtt_if.sv
hdl/nvtt_datapath.sv
hdl/nvtt_ctrl.sv
hdl/note_voice_tracking_table.sv
test/tb_note_voice_tracking_table.sv
